FILE: src/gphid_pkg.sv
// package: packet and report types, descramble function and code constants
`default_nettype none

package gphid_pkg;

    localparam logic [7:0] SCRAMBLE_KEY = 8'h17;

    // pad mode codes
    localparam logic PAD_MODE_ACCEL = 1'b0;
    localparam logic PAD_MODE_DUAL  = 1'b1;
    localparam logic PAD_MODE_RESET = PAD_MODE_ACCEL;

    // hat codes, clockwise from up
    localparam logic [3:0] HAT_UP         = 4'd0;
    localparam logic [3:0] HAT_UP_RIGHT   = 4'd1;
    localparam logic [3:0] HAT_RIGHT      = 4'd2;
    localparam logic [3:0] HAT_DOWN_RIGHT = 4'd3;
    localparam logic [3:0] HAT_DOWN       = 4'd4;
    localparam logic [3:0] HAT_DOWN_LEFT  = 4'd5;
    localparam logic [3:0] HAT_LEFT       = 4'd6;
    localparam logic [3:0] HAT_UP_LEFT    = 4'd7;
    localparam logic [3:0] HAT_CENTRED    = 4'd8;

    typedef struct packed {
        logic [7:0] raw_byte0;
        logic [7:0] raw_byte1;
        logic [7:0] raw_byte2;
        logic [7:0] raw_byte3;
        logic [7:0] raw_byte4;
        logic [7:0] raw_byte5;
    } pkt_t;

    typedef struct packed {
        logic [7:0] button_byte_a;
        logic [7:0] button_byte_b;
        logic [3:0] hat_code;
        logic [7:0] left_x;
        logic [7:0] left_y;
        logic [7:0] report_byte5;
        logic [7:0] report_byte6;
        logic [7:0] report_byte7;
    } rpt_t;

    // sum wraps at eight bits
    function automatic logic [7:0] descramble(input logic [7:0] raw);
        logic [7:0] mixed;
        mixed = raw ^ SCRAMBLE_KEY;
        return mixed + SCRAMBLE_KEY;
    endfunction

endpackage

`default_nettype wire

FILE: src/gphid_if.sv
// interfaces: packet input channel and report output channel
`default_nettype none

interface gphid_pkt_if
    import gphid_pkg::*;
();
    logic valid;
    logic ready;
    pkt_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface gphid_rpt_if
    import gphid_pkg::*;
();
    logic valid;
    logic ready;
    rpt_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: src/gamepad_packet_to_hid_report.sv
// top level: packet register, descramble and mapping, report register
//
//   channel   dir  handshake        payload
//   pkt       in   valid / ready    pkt_t, six scrambled bytes
//   rpt       out  valid / ready    rpt_t, eight-field report
//   cfg       in   cfg_we           cfg_wdata, pad mode bit
//
// two register stages: a taken packet goes via the packet and report registers to rpt
// one packet per cycle sustained while rpt is ready; the mapping between the stages
// is pure wiring plus a few xor/add bits, so the report register is the only limit
// reset clears both valid flags and sets the pad mode to the accelerometer pad
// a stall on rpt holds the report; the packet stage still fills, then pkt.ready drops
`default_nettype none

module gamepad_packet_to_hid_report
    import gphid_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  cfg_we,
    input  wire logic  cfg_wdata,
    gphid_pkt_if.sink   pkt,
    gphid_rpt_if.source rpt
);

    logic       mode_reg;
    logic       pkt_valid_reg;
    pkt_t       pkt_reg;
    logic       rpt_valid_reg;
    rpt_t       rpt_reg;
    rpt_t       rpt_next;
    logic       advance;
    logic [7:0] d0, d1, d2, d3, d4, d5;
    logic [4:0] rx5, ry5, lt5;
    logic       up, dn, rt, lf;

    assign advance   = !rpt_valid_reg || rpt.ready;
    assign pkt.ready = !pkt_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= PAD_MODE_RESET;
        end
        else if (cfg_we)
        begin
            mode_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pkt_valid_reg <= 1'b0;
            rpt_valid_reg <= 1'b0;
        end
        else
        begin
            if (pkt.ready)
            begin
                pkt_valid_reg <= pkt.valid;
            end
            if (advance)
            begin
                rpt_valid_reg <= pkt_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pkt.valid && pkt.ready)
        begin
            pkt_reg <= pkt.data;
        end
        if (advance && pkt_valid_reg)
        begin
            rpt_reg <= rpt_next;
        end
    end

    always_comb
    begin
        d0 = descramble(pkt_reg.raw_byte0);
        d1 = descramble(pkt_reg.raw_byte1);
        d2 = descramble(pkt_reg.raw_byte2);
        d3 = descramble(pkt_reg.raw_byte3);
        d4 = descramble(pkt_reg.raw_byte4);
        d5 = descramble(pkt_reg.raw_byte5);

        // packed stick and trigger fields of the dual-stick pad
        rx5 = {d0[7:6], d1[7:6], d2[7]};
        ry5 = d2[4:0];
        lt5 = {d2[6:5], d3[7:5]};

        // directions, active low
        up = !d5[0];
        dn = !d4[6];
        rt = !d4[7];
        lf = !d5[1];

        rpt_next = '0;
        case (mode_reg)
            PAD_MODE_ACCEL:
            begin
                rpt_next.left_x        = d0;
                rpt_next.left_y        = ~d1;
                rpt_next.report_byte5  = d2;
                rpt_next.report_byte6  = d3;
                rpt_next.report_byte7  = d4;
                rpt_next.button_byte_a = {5'b0, !d5[1], !d5[0], 1'b0};
                rpt_next.button_byte_b = 8'h00;
                rpt_next.hat_code      = HAT_CENTRED;
            end
            default:
            begin
                rpt_next.left_x        = {d0[5:0], 2'b00};
                rpt_next.left_y        = ~{d1[5:0], 2'b00};
                rpt_next.report_byte5  = {rx5, 3'b000};
                rpt_next.report_byte6  = ~{lt5, 3'b000};
                rpt_next.report_byte7  = ~{ry5, 3'b000};
                rpt_next.button_byte_a = {!d5[2], !d5[7], !d4[1], !d4[5],
                                          !d5[3], !d5[4], !d5[6], !d5[5]};
                rpt_next.button_byte_b = {3'b000, !d4[3], 2'b00, !d4[2], !d4[4]};
                // up beats down, left beats right
                if (up)
                begin
                    rpt_next.hat_code = lf ? HAT_UP_LEFT : (rt ? HAT_UP_RIGHT : HAT_UP);
                end
                else if (dn)
                begin
                    rpt_next.hat_code = lf ? HAT_DOWN_LEFT
                                           : (rt ? HAT_DOWN_RIGHT : HAT_DOWN);
                end
                else
                begin
                    rpt_next.hat_code = lf ? HAT_LEFT : (rt ? HAT_RIGHT : HAT_CENTRED);
                end
            end
        endcase
    end

    assign rpt.valid = rpt_valid_reg;
    assign rpt.data  = rpt_reg;

`ifndef ASSERT_OFF
    a_pkt_to_stage: assert property (@(posedge clk) disable iff (!rst_n)
        (pkt.valid && pkt.ready) |=> pkt_valid_reg)
        else $error("accepted packet beat not held in packet stage");

    a_stage_to_rpt: assert property (@(posedge clk) disable iff (!rst_n)
        (pkt_valid_reg && advance) |=> rpt_valid_reg)
        else $error("packet stage moved on without a report");

    a_hat_range: assert property (@(posedge clk) disable iff (!rst_n)
        rpt_valid_reg |-> (rpt_reg.hat_code <= HAT_CENTRED))
        else $error("hat code out of range");

    a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
        (pkt_valid_reg && !advance) |=> pkt_valid_reg)
        else $error("stalled packet dropped");
`endif

endmodule

`default_nettype wire

FILE: bench/tb_gamepad_packet_to_hid_report.sv
// testbench: packet-to-report converter checked against its own mapping predictor
`timescale 1ns / 100ps

module tb_gamepad_packet_to_hid_report;
    import gphid_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned SHOWN_MISMATCHES = 10;

    class report_scoreboard;
        rpt_t        pending_reports[$];
        logic        pad_mode;
        int unsigned mismatches;

        function new();
            pad_mode   = PAD_MODE_RESET;
            mismatches = 0;
        endfunction

        function logic [7:0] unmix(input logic [7:0] raw);
            logic [7:0] flipped;
            flipped = raw ^ SCRAMBLE_KEY;
            return flipped + SCRAMBLE_KEY;
        endfunction

        function rpt_t map_packet(input pkt_t p);
            logic [7:0] d [6];
            logic [4:0] rx5, ry5, lt5;
            logic       up, dn, rt, lf;
            rpt_t       r;
            d[0] = unmix(p.raw_byte0);
            d[1] = unmix(p.raw_byte1);
            d[2] = unmix(p.raw_byte2);
            d[3] = unmix(p.raw_byte3);
            d[4] = unmix(p.raw_byte4);
            d[5] = unmix(p.raw_byte5);
            r = '0;
            if (pad_mode == PAD_MODE_ACCEL)
            begin
                r.left_x        = d[0];
                r.left_y        = ~d[1];
                r.report_byte5  = d[2];
                r.report_byte6  = d[3];
                r.report_byte7  = d[4];
                r.button_byte_a = {5'b0, ~d[5][1], ~d[5][0], 1'b0};
                r.button_byte_b = 8'h00;
                r.hat_code      = HAT_CENTRED;
            end
            else
            begin
                rx5 = {d[0][7:6], d[1][7:6], d[2][7]};
                ry5 = d[2][4:0];
                lt5 = {d[2][6:5], d[3][7:5]};
                r.left_x       = {d[0][5:0], 2'b00};
                r.left_y       = ~{d[1][5:0], 2'b00};
                r.report_byte5 = {rx5, 3'b000};
                r.report_byte6 = ~{lt5, 3'b000};
                r.report_byte7 = ~{ry5, 3'b000};
                // direction bits are active low; up beats down, left beats right
                up = ~d[5][0];
                dn = ~d[4][6];
                rt = ~d[4][7];
                lf = ~d[5][1];
                if (up)
                    r.hat_code = lf ? HAT_UP_LEFT : (rt ? HAT_UP_RIGHT : HAT_UP);
                else if (dn)
                    r.hat_code = lf ? HAT_DOWN_LEFT : (rt ? HAT_DOWN_RIGHT : HAT_DOWN);
                else
                    r.hat_code = lf ? HAT_LEFT : (rt ? HAT_RIGHT : HAT_CENTRED);
                r.button_byte_b = {3'b000, ~d[4][3], 2'b00, ~d[4][2], ~d[4][4]};
                r.button_byte_a = {~d[5][2], ~d[5][7], ~d[4][1], ~d[4][5],
                                   ~d[5][3], ~d[5][4], ~d[5][6], ~d[5][5]};
            end
            return r;
        endfunction

        function void take_packet(input pkt_t p);
            pending_reports.push_back(map_packet(p));
        endfunction

        function void flag(input string what, input logic [63:0] want,
                           input logic [63:0] got);
            mismatches++;
            if (mismatches <= SHOWN_MISMATCHES)
                $display("mismatch on %0s: expected %0h, got %0h", what, want, got);
        endfunction

        function void check_report(input rpt_t got);
            rpt_t want;
            if (pending_reports.size() == 0)
            begin
                flag("report with nothing pending", 64'd0, 64'(got));
                return;
            end
            want = pending_reports.pop_front();
            if (got.button_byte_a !== want.button_byte_a)
                flag("button_byte_a", 64'(want.button_byte_a), 64'(got.button_byte_a));
            if (got.button_byte_b !== want.button_byte_b)
                flag("button_byte_b", 64'(want.button_byte_b), 64'(got.button_byte_b));
            if (got.hat_code !== want.hat_code)
                flag("hat_code", 64'(want.hat_code), 64'(got.hat_code));
            if (got.left_x !== want.left_x)
                flag("left_x", 64'(want.left_x), 64'(got.left_x));
            if (got.left_y !== want.left_y)
                flag("left_y", 64'(want.left_y), 64'(got.left_y));
            if (got.report_byte5 !== want.report_byte5)
                flag("report_byte5", 64'(want.report_byte5), 64'(got.report_byte5));
            if (got.report_byte6 !== want.report_byte6)
                flag("report_byte6", 64'(want.report_byte6), 64'(got.report_byte6));
            if (got.report_byte7 !== want.report_byte7)
                flag("report_byte7", 64'(want.report_byte7), 64'(got.report_byte7));
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    gphid_pkt_if pkt_ch ();
    gphid_rpt_if rpt_ch ();

    report_scoreboard sb;

    int unsigned send_gap_pct;
    int unsigned recv_gap_pct;
    int unsigned hold_req;
    int unsigned idle_cycles;

    gamepad_packet_to_hid_report i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .pkt       (pkt_ch),
        .rpt       (rpt_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // inverse of the descramble, so directed packets can be given as plain bytes
    function automatic logic [7:0] to_wire(input logic [7:0] plain);
        return (plain - SCRAMBLE_KEY) ^ SCRAMBLE_KEY;
    endfunction

    function automatic pkt_t plain_packet(input logic [7:0] d0, input logic [7:0] d1,
                                          input logic [7:0] d2, input logic [7:0] d3,
                                          input logic [7:0] d4, input logic [7:0] d5);
        return {to_wire(d0), to_wire(d1), to_wire(d2), to_wire(d3), to_wire(d4),
                to_wire(d5)};
    endfunction

    function automatic logic [7:0] edge_or_random();
        case ($urandom_range(2))
            0: return 8'h00;
            1: return 8'hff;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic pkt_t random_packet();
        logic [47:0] bits;
        if ($urandom_range(3) == 0)
            return plain_packet(edge_or_random(), edge_or_random(), edge_or_random(),
                                edge_or_random(), edge_or_random(), edge_or_random());
        bits = {32'($urandom), 16'($urandom)};
        return bits;
    endfunction

    // entered and left at a falling edge
    task automatic send_packet(input pkt_t p);
        while ($urandom_range(99) < send_gap_pct)
        begin
            pkt_ch.valid <= 1'b0;
            @(negedge clk);
        end
        pkt_ch.valid <= 1'b1;
        pkt_ch.data  <= p;
        @(posedge clk);
        while (!pkt_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_random(input int unsigned count);
        repeat (count)
            send_packet(random_packet());
    endtask

    // stop offering and wait until every report is out and the pipe is empty
    task automatic settle();
        pkt_ch.valid <= 1'b0;
        while (sb.pending_reports.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_mode(input logic mode);
        cfg_we    <= 1'b1;
        cfg_wdata <= mode;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.pad_mode = mode;
    endtask

    // receiver: random ready, or a long hold-off when one is requested
    initial
    begin
        int unsigned hold_left;
        hold_left = 0;
        rpt_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req != 0)
            begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                rpt_ch.ready <= 1'b0;
            end
            else
                rpt_ch.ready <= ($urandom_range(99) >= recv_gap_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pkt_ch.valid && pkt_ch.ready)
                sb.take_packet(pkt_ch.data);
            if (rpt_ch.valid && rpt_ch.ready)
                sb.check_report(rpt_ch.data);
        end
    end

    always @(posedge clk)
    begin
        if ((pkt_ch.valid && pkt_ch.ready) || (rpt_ch.valid && rpt_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        int k;
        logic [7:0] fill, b4, b5;

        sb           = new();
        idle_cycles  = 0;
        hold_req     = 0;
        send_gap_pct = 0;
        recv_gap_pct = 0;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = 1'b0;
        pkt_ch.valid = 1'b0;
        pkt_ch.data  = '0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // accelerometer pad: both buttons, both stick extremes, raw extremes
        write_mode(PAD_MODE_ACCEL);
        send_packet('0);
        send_packet('1);
        for (k = 0; k < 4; k++)
        begin
            fill = k[0] ? 8'hff : 8'h00;
            send_packet(plain_packet(fill, fill, fill, fill, fill, {6'h2a, k[1:0]}));
        end
        settle();

        // dual-stick pad: every combination of the four direction bits
        write_mode(PAD_MODE_DUAL);
        send_packet('0);
        send_packet('1);
        for (k = 0; k < 16; k++)
        begin
            fill = (k < 8) ? 8'hff : 8'h00;
            b4 = fill;
            b5 = fill;
            b4[7] = ~k[3];
            b4[6] = ~k[2];
            b5[1] = ~k[1];
            b5[0] = ~k[0];
            send_packet(plain_packet(~fill, fill, ~fill, fill, b4, b5));
        end

        // slow receiver
        send_gap_pct = 34;
        recv_gap_pct = 80;
        send_random(180);

        // long hold-off on the report side while packets keep coming
        send_gap_pct = 0;
        hold_req = 60;
        send_random(12);
        settle();

        // slow sender
        write_mode(PAD_MODE_ACCEL);
        send_gap_pct = 80;
        recv_gap_pct = 34;
        send_random(180);
        settle();

        // back to back
        write_mode(PAD_MODE_DUAL);
        send_gap_pct = 0;
        recv_gap_pct = 0;
        send_random(100);
        settle();
        write_mode(PAD_MODE_ACCEL);
        send_random(90);

        settle();
        repeat (8) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending_reports.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: gamepad_packet_to_hid_report.f
src/gphid_pkg.sv
src/gphid_if.sv
src/gamepad_packet_to_hid_report.sv
bench/tb_gamepad_packet_to_hid_report.sv
